// File: src/dprc_pkg.sv
// ----------------------------------------------------------------------------
// dprc_pkg: shared types, constants and arithmetic helpers
// Q12.20 helpers, channel structs and op codes for depth to color registration.
// ----------------------------------------------------------------------------
package dprc_pkg;

   localparam int IMAGE_COLS    = 640;
   localparam int IMAGE_ROWS    = 480;
   localparam int TABLE_ENTRIES = 2048;
   localparam int TAB_AW        = $clog2(TABLE_ENTRIES);

   localparam int ROW_W  = 9;
   localparam int COL_W  = 10;
   localparam int CODE_W = 11;
   localparam int IDX_W  = 11;
   localparam int Q_W    = 32;
   localparam int FRAC   = 20;
   localparam int CSR_AW = 3;

   localparam int COEF_N  = 16;
   localparam int COEF_AW = 4;
   localparam int C_FX    = 0;
   localparam int C_FY    = 1;
   localparam int C_ROT   = 2;
   localparam int C_TRN   = 11;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int DIV_NB = Q_W + FRAC;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_TABLE = 2'd1,
      OP_COEF  = 2'd2,
      OP_NONE  = 2'd3
   } dprc_op_type;

   typedef struct packed {
      logic [CODE_W-1:0]     depth_limit;
      logic signed [Q_W-1:0] dcx;
      logic signed [Q_W-1:0] dcy;
      logic signed [Q_W-1:0] difx;
      logic signed [Q_W-1:0] dify;
      logic signed [Q_W-1:0] ccx;
      logic signed [Q_W-1:0] ccy;
   } dprc_cfg_type;

   typedef logic [COEF_N-1:0][Q_W-1:0] dprc_coef_type;

   typedef struct packed {
      logic [ROW_W-1:0]      row;
      logic [COL_W-1:0]      col;
      logic signed [Q_W-1:0] z;
   } dprc_pix_type;

   typedef struct packed {
      logic [ROW_W-1:0]      row;
      logic [COL_W-1:0]      col;
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
      logic signed [Q_W-1:0] z;
      logic                  zero;
   } dprc_item_type;

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[Q_W-1:0];
   endfunction

   function automatic logic signed [Q_W-1:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd524288) >>> FRAC;
      return sat32(t);
   endfunction

endpackage

// File: src/dprc_front.sv
// ----------------------------------------------------------------------------
// dprc_front: request intake
// Holds the config registers, coefficient store and depth table; classifies
// requests, performs writes and pushes surviving pixels with their z.
// ----------------------------------------------------------------------------
module dprc_front import dprc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [ROW_W-1:0]      req_pixel_row,
   input  logic [COL_W-1:0]      req_pixel_col,
   input  logic [CODE_W-1:0]     req_depth_code,
   input  logic [IDX_W-1:0]      req_write_index,
   input  logic signed [Q_W-1:0] req_write_value,
   input  logic                  csr_wr_en,
   input  logic [CSR_AW-1:0]     csr_index,
   input  logic [Q_W-1:0]        csr_wdata,
   input  logic                  q_afull,
   input  logic                  q_empty,
   input  logic                  back_busy,
   output logic                  push,
   output dprc_pix_type          push_pix,
   output dprc_cfg_type          cfg,
   output dprc_coef_type         coef
);

   typedef enum logic [CSR_AW-1:0] {
      REG_DEPTH_LIMIT = 3'd0,
      REG_DEPTH_CX    = 3'd1,
      REG_DEPTH_CY    = 3'd2,
      REG_DEPTH_IFX   = 3'd3,
      REG_DEPTH_IFY   = 3'd4,
      REG_COLOR_CX    = 3'd5,
      REG_COLOR_CY    = 3'd6
   } reg_idx_type;

   logic signed [Q_W-1:0] table_mem [TABLE_ENTRIES];

   dprc_cfg_type  cfg_ff, cfg_in;
   dprc_coef_type coef_ff;
   dprc_pix_type  pix_ff;
   logic          s1_valid_ff, s1_valid_in;
   dprc_op_type   op;
   logic          accept, coef_hold, keep_pix;

   assign op        = dprc_op_type'(req_op);
   assign coef_hold = (op == OP_COEF) && (s1_valid_ff || !q_empty || back_busy);
   assign req_stall = q_afull || coef_hold;
   assign accept    = req_valid && !req_stall;
   assign keep_pix  = accept && (op == OP_PIXEL) && (req_depth_code < cfg_ff.depth_limit);
   assign s1_valid_in = keep_pix;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_DEPTH_LIMIT: cfg_in.depth_limit = csr_wdata[CODE_W-1:0];
            REG_DEPTH_CX:    cfg_in.dcx  = csr_wdata;
            REG_DEPTH_CY:    cfg_in.dcy  = csr_wdata;
            REG_DEPTH_IFX:   cfg_in.difx = csr_wdata;
            REG_DEPTH_IFY:   cfg_in.dify = csr_wdata;
            REG_COLOR_CX:    cfg_in.ccx  = csr_wdata;
            REG_COLOR_CY:    cfg_in.ccy  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_limit <= 11'd2047;
         cfg_ff.dcx         <= 32'sd335020032;
         cfg_ff.dcy         <= 32'sd251133952;
         cfg_ff.difx        <= 32'sd1789;
         cfg_ff.dify        <= 32'sd1795;
         cfg_ff.ccx         <= 32'sd328176041;
         cfg_ff.ccy         <= 32'sd277878963;
         s1_valid_ff        <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep_pix) begin
         pix_ff.z   <= table_mem[TAB_AW'(req_depth_code)];
         pix_ff.row <= req_pixel_row;
         pix_ff.col <= req_pixel_col;
      end
      if (accept && (op == OP_TABLE)) begin
         table_mem[TAB_AW'(req_write_index)] <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (op == OP_COEF) && (req_write_index < IDX_W'(COEF_N))) begin
         coef_ff[req_write_index[COEF_AW-1:0]] <= req_write_value;
      end
   end

   assign push     = s1_valid_ff;
   assign push_pix = pix_ff;
   assign cfg      = cfg_ff;
   assign coef     = coef_ff;

endmodule

// File: src/dprc_queue.sv
// ----------------------------------------------------------------------------
// dprc_queue: short pixel queue
// Decouples request intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module dprc_queue import dprc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  dprc_pix_type   push_pix,
   input  logic           pop,
   output dprc_pix_type   head,
   output logic           empty,
   output logic           afull,
   output logic [QAW:0]   count
);

   dprc_pix_type     slot_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]     count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_pix;
      end
   end

   assign head  = slot_ff[rd_ff];
   assign empty = (count_ff == '0);
   assign afull = (count_ff >= (QAW+1)'(QDEPTH-1));
   assign count = count_ff;

endmodule

// File: src/dprc_div.sv
// ----------------------------------------------------------------------------
// dprc_div: pipelined two-lane divider
// Restoring division of |num|*2^20 by |den|, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dprc_div import dprc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  dprc_item_type         in_item,
   input  logic signed [Q_W-1:0] num_x,
   input  logic signed [Q_W-1:0] num_y,
   input  logic signed [Q_W-1:0] den,
   output logic                  out_valid,
   output dprc_item_type         out_item,
   output logic [DIV_NB-1:0]     out_qx,
   output logic [DIV_NB-1:0]     out_qy,
   output logic                  out_negx,
   output logic                  out_negy,
   output logic                  out_rx_nz,
   output logic                  out_ry_nz,
   output logic                  busy
);

   logic [DIV_NB-1:0] v_ff;
   dprc_item_type     it_ff  [DIV_NB];
   logic [Q_W-1:0]    d_ff   [DIV_NB];
   logic [Q_W-1:0]    d_in   [DIV_NB];
   logic [Q_W-1:0]    rx_ff  [DIV_NB];
   logic [Q_W-1:0]    rx_in  [DIV_NB];
   logic [Q_W-1:0]    ry_ff  [DIV_NB];
   logic [Q_W-1:0]    ry_in  [DIV_NB];
   logic [DIV_NB-1:0] nqx_ff [DIV_NB];
   logic [DIV_NB-1:0] nqx_in [DIV_NB];
   logic [DIV_NB-1:0] nqy_ff [DIV_NB];
   logic [DIV_NB-1:0] nqy_in [DIV_NB];
   logic              negx_ff [DIV_NB];
   logic              negy_ff [DIV_NB];

   function automatic logic [Q_W-1:0] abs32(input logic signed [Q_W-1:0] a);
      return a[Q_W-1] ? Q_W'(-a) : a;
   endfunction

   function automatic logic [Q_W+DIV_NB-1:0] step(input logic [Q_W-1:0] rem,
                                                  input logic [DIV_NB-1:0] nq,
                                                  input logic [Q_W-1:0] d);
      logic [Q_W:0]   trial;
      logic [Q_W-1:0] r;
      logic           b;
      trial = {rem, nq[DIV_NB-1]};
      if (trial >= {1'b0, d}) begin
         r = Q_W'(trial - {1'b0, d});
         b = 1'b1;
      end else begin
         r = trial[Q_W-1:0];
         b = 1'b0;
      end
      return {r, nq[DIV_NB-2:0], b};
   endfunction

   always_comb begin
      for (int k = 0; k < DIV_NB; k++) begin
         if (k == 0) begin
            d_in[k] = abs32(den);
            {rx_in[k], nqx_in[k]} = step('0, {abs32(num_x), {FRAC{1'b0}}}, d_in[k]);
            {ry_in[k], nqy_in[k]} = step('0, {abs32(num_y), {FRAC{1'b0}}}, d_in[k]);
         end else begin
            d_in[k] = d_ff[k-1];
            {rx_in[k], nqx_in[k]} = step(rx_ff[k-1], nqx_ff[k-1], d_ff[k-1]);
            {ry_in[k], nqy_in[k]} = step(ry_ff[k-1], nqy_ff[k-1], d_ff[k-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DIV_NB-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_NB; k++) begin
            d_ff[k]   <= d_in[k];
            rx_ff[k]  <= rx_in[k];
            ry_ff[k]  <= ry_in[k];
            nqx_ff[k] <= nqx_in[k];
            nqy_ff[k] <= nqy_in[k];
            if (k == 0) begin
               it_ff[k]   <= in_item;
               negx_ff[k] <= num_x[Q_W-1] ^ den[Q_W-1];
               negy_ff[k] <= num_y[Q_W-1] ^ den[Q_W-1];
            end else begin
               it_ff[k]   <= it_ff[k-1];
               negx_ff[k] <= negx_ff[k-1];
               negy_ff[k] <= negy_ff[k-1];
            end
         end
      end
   end

   assign out_valid = v_ff[DIV_NB-1];
   assign out_item  = it_ff[DIV_NB-1];
   assign out_qx    = nqx_ff[DIV_NB-1];
   assign out_qy    = nqy_ff[DIV_NB-1];
   assign out_negx  = negx_ff[DIV_NB-1];
   assign out_negy  = negy_ff[DIV_NB-1];
   assign out_rx_nz = (rx_ff[DIV_NB-1] != '0);
   assign out_ry_nz = (ry_ff[DIV_NB-1] != '0);
   assign busy      = |v_ff;

endmodule

// File: src/dprc_back.sv
// ----------------------------------------------------------------------------
// dprc_back: point and color pixel pipeline
// Back-projects the pixel, applies the rigid transform, divides by tz and
// rounds and clamps the color pixel into the response register.
// ----------------------------------------------------------------------------
module dprc_back import dprc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dprc_cfg_type          cfg,
   input  dprc_coef_type         coef,
   input  logic                  in_valid,
   input  dprc_pix_type          in_pix,
   output logic                  pop,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic signed [Q_W-1:0] rsp_point_x,
   output logic signed [Q_W-1:0] rsp_point_y,
   output logic signed [Q_W-1:0] rsp_point_z,
   output logic [ROW_W-1:0]      rsp_color_row,
   output logic [COL_W-1:0]      rsp_color_col
);

   localparam int PRE_ST = 10;

   logic adv;
   logic [PRE_ST-1:0] v_ff;
   logic [1:0]        pv_ff;
   logic              rsp_valid_ff;
   dprc_item_type     it_ff [PRE_ST];
   dprc_item_type     it_in [PRE_ST];

   logic signed [Q_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [63:0]    pxa_ff, pya_ff, pxa_in, pya_in;
   logic signed [Q_W-1:0] mx_ff, my_ff, mx_in, my_in;
   logic signed [63:0]    pxb_ff, pyb_ff, pxb_in, pyb_in;
   logic signed [63:0]    prod_ff [9];
   logic signed [63:0]    prod_in [9];
   logic signed [Q_W-1:0] term_ff [9];
   logic signed [Q_W-1:0] term_in [9];
   logic signed [Q_W-1:0] tr_ff [3];
   logic signed [Q_W-1:0] tr_in [3];
   logic signed [Q_W-1:0] xyz [3];
   logic signed [63:0]    pcx_ff, pcy_ff, pcx_in, pcy_in;
   logic signed [Q_W-1:0] tz9_ff, tz10_ff;
   logic signed [Q_W-1:0] nx_ff, ny_ff, nx_in, ny_in;

   logic                  dv_valid, dv_negx, dv_negy, dv_rxnz, dv_rynz, dv_busy;
   dprc_item_type         dv_item;
   logic [DIV_NB-1:0]     dv_qx, dv_qy;

   dprc_item_type         p1_it_ff, p2_it_ff, rsp_it_ff;
   logic signed [DIV_NB:0]   qx_ff, qy_ff, qx_in, qy_in;
   logic signed [DIV_NB+1:0] vx_ff, vy_ff, vx_in, vy_in;
   logic signed [DIV_NB+1:0] rcx, rcy;
   logic [ROW_W-1:0]      crow_ff, crow_in;
   logic [COL_W-1:0]      ccol_ff, ccol_in;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && in_valid;

   always_comb begin
      logic signed [63:0] tx, ty;
      tx = $signed({34'd0, in_pix.col, {FRAC{1'b0}}}) - 64'(cfg.dcx);
      ty = $signed({35'd0, in_pix.row, {FRAC{1'b0}}}) - 64'(cfg.dcy);
      dx_in = sat32(tx);
      dy_in = sat32(ty);
      pxa_in = dx_ff * it_ff[0].z;
      pya_in = dy_ff * it_ff[0].z;
      mx_in = qround(pxa_ff);
      my_in = qround(pya_ff);
      pxb_in = mx_ff * cfg.difx;
      pyb_in = my_ff * cfg.dify;
      for (int i = 0; i < PRE_ST; i++) begin
         it_in[i] = (i == 0) ? it_ff[0] : it_ff[i-1];
      end
      it_in[0].row  = in_pix.row;
      it_in[0].col  = in_pix.col;
      it_in[0].z    = in_pix.z;
      it_in[0].x    = '0;
      it_in[0].y    = '0;
      it_in[0].zero = 1'b0;
      it_in[4].x = qround(pxb_ff);
      it_in[4].y = qround(pyb_ff);
      xyz[0] = it_ff[4].x;
      xyz[1] = it_ff[4].y;
      xyz[2] = it_ff[4].z;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = $signed(coef[C_ROT+3*r+c]) * xyz[c];
         end
      end
      for (int i = 0; i < 9; i++) begin
         term_in[i] = qround(prod_ff[i]);
      end
      for (int r = 0; r < 3; r++) begin
         tr_in[r] = sat32(64'(34'(term_ff[3*r]) + 34'(term_ff[3*r+1])
                    + 34'(term_ff[3*r+2]) + 34'($signed(coef[C_TRN+r]))));
      end
      pcx_in = tr_ff[0] * $signed(coef[C_FX]);
      pcy_in = tr_ff[1] * $signed(coef[C_FY]);
      it_in[8].zero = (tr_ff[2] == '0);
      nx_in = qround(pcx_ff);
      ny_in = qround(pcy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[PRE_ST-2:0], in_valid};
         pv_ff        <= {pv_ff[0], dv_valid};
         rsp_valid_ff <= pv_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < PRE_ST; i++) begin
            it_ff[i] <= it_in[i];
         end
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         pxa_ff <= pxa_in;
         pya_ff <= pya_in;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         pxb_ff <= pxb_in;
         pyb_ff <= pyb_in;
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_in[i];
            term_ff[i] <= term_in[i];
         end
         for (int r = 0; r < 3; r++) begin
            tr_ff[r] <= tr_in[r];
         end
         pcx_ff  <= pcx_in;
         pcy_ff  <= pcy_in;
         tz9_ff  <= tr_ff[2];
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         tz10_ff <= tz9_ff;
      end
   end

   dprc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_ff[PRE_ST-1]),
      .in_item   (it_ff[PRE_ST-1]),
      .num_x     (nx_ff),
      .num_y     (ny_ff),
      .den       (tz10_ff),
      .out_valid (dv_valid),
      .out_item  (dv_item),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_negx  (dv_negx),
      .out_negy  (dv_negy),
      .out_rx_nz (dv_rxnz),
      .out_ry_nz (dv_rynz),
      .busy      (dv_busy)
   );

   always_comb begin
      logic signed [DIV_NB:0] ax, ay;
      ax = $signed({1'b0, dv_qx});
      ay = $signed({1'b0, dv_qy});
      qx_in = dv_negx ? (-ax - (DIV_NB+1)'(dv_rxnz)) : ax;
      qy_in = dv_negy ? (-ay - (DIV_NB+1)'(dv_rynz)) : ay;
      vx_in = (DIV_NB+2)'(qx_ff) + (DIV_NB+2)'(cfg.ccx);
      vy_in = (DIV_NB+2)'(qy_ff) + (DIV_NB+2)'(cfg.ccy);
      rcx = (vx_ff + (DIV_NB+2)'(524288)) >>> FRAC;
      rcy = (vy_ff + (DIV_NB+2)'(524288)) >>> FRAC;
      priority if (p2_it_ff.zero || (rcx < 0)) begin
         ccol_in = '0;
      end else if (rcx > (DIV_NB+2)'(IMAGE_COLS-1)) begin
         ccol_in = COL_W'(IMAGE_COLS-1);
      end else begin
         ccol_in = rcx[COL_W-1:0];
      end
      priority if (p2_it_ff.zero || (rcy < 0)) begin
         crow_in = '0;
      end else if (rcy > (DIV_NB+2)'(IMAGE_ROWS-1)) begin
         crow_in = ROW_W'(IMAGE_ROWS-1);
      end else begin
         crow_in = rcy[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_it_ff  <= dv_item;
         qx_ff     <= qx_in;
         qy_ff     <= qy_in;
         p2_it_ff  <= p1_it_ff;
         vx_ff     <= vx_in;
         vy_ff     <= vy_in;
         rsp_it_ff <= p2_it_ff;
         ccol_ff   <= ccol_in;
         crow_ff   <= crow_in;
      end
   end

   assign busy          = (|v_ff) || dv_busy || (|pv_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_it_ff.row;
   assign rsp_out_col   = rsp_it_ff.col;
   assign rsp_point_x   = rsp_it_ff.x;
   assign rsp_point_y   = rsp_it_ff.y;
   assign rsp_point_z   = rsp_it_ff.z;
   assign rsp_color_row = crow_ff;
   assign rsp_color_col = ccol_ff;

endmodule

// File: src/depth_pixel_to_point_and_color_index.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point_and_color_index: depth pixel registration top level
// Throughput: one request per cycle unless the pixel queue is almost full; a
//   coefficient write waits until all pixels ahead of it have left the
//   arithmetic pipeline. Path: request register, queue, ten arithmetic
//   stages, the 52-stage divider and the output registers.
// Reset: config registers take their defaults and all pipelines empty;
//   depth table and coefficients hold no value until written.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_and_color_index import dprc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [ROW_W-1:0]      req_pixel_row,
   input  logic [COL_W-1:0]      req_pixel_col,
   input  logic [CODE_W-1:0]     req_depth_code,
   input  logic [IDX_W-1:0]      req_write_index,
   input  logic signed [Q_W-1:0] req_write_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic signed [Q_W-1:0] rsp_point_x,
   output logic signed [Q_W-1:0] rsp_point_y,
   output logic signed [Q_W-1:0] rsp_point_z,
   output logic [ROW_W-1:0]      rsp_color_row,
   output logic [COL_W-1:0]      rsp_color_col,
   input  logic                  csr_wr_en,
   input  logic [CSR_AW-1:0]     csr_index,
   input  logic [Q_W-1:0]        csr_wdata
);

   logic          q_push, q_pop, q_empty, q_afull, back_busy;
   logic [QAW:0]  q_count;
   dprc_pix_type  push_pix, head_pix;
   dprc_cfg_type  cfg;
   dprc_coef_type coef;

   dprc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_col   (req_pixel_col),
      .req_depth_code  (req_depth_code),
      .req_write_index (req_write_index),
      .req_write_value (req_write_value),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_afull         (q_afull),
      .q_empty         (q_empty),
      .back_busy       (back_busy),
      .push            (q_push),
      .push_pix        (push_pix),
      .cfg             (cfg),
      .coef            (coef)
   );

   dprc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_pix (push_pix),
      .pop      (q_pop),
      .head     (head_pix),
      .empty    (q_empty),
      .afull    (q_afull),
      .count    (q_count)
   );

   dprc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .coef          (coef),
      .in_valid      (!q_empty),
      .in_pix        (head_pix),
      .pop           (q_pop),
      .busy          (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_color_row (rsp_color_row),
      .rsp_color_col (rsp_color_col)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_pop |-> q_count != (QAW+1)'(QDEPTH))
      else $error("pixel queue overflow");

   a_coef_write_drained: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_COEF |-> !back_busy && q_empty)
      else $error("coefficient write while pixels in flight");

   a_drop_far_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_PIXEL
      && req_depth_code >= cfg.depth_limit |=> !q_push)
      else $error("dropped pixel pushed to queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

// File: tb/depth_pixel_to_point_and_color_index_tb.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point_and_color_index_tb: registration self-checking bench
// Loads the depth table and transform coefficients, then streams directed and
// random pixel, write and no-op requests through several register settings.
// Every response is compared field by field with a bit-exact Q12.20 point and
// color index predictor, with random gaps on both channels in some phases.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_and_color_index_tb;
   import dprc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q_ONE  = 64'sd1048576;
   localparam longint Q_HALF = 64'sd524288;

   typedef struct {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [Q_W-1:0]   x;
      logic [Q_W-1:0]   y;
      logic [Q_W-1:0]   z;
      logic [ROW_W-1:0] crow;
      logic [COL_W-1:0] ccol;
   } point_type;

   typedef struct {
      dprc_op_type op;
      int          prow;
      int          pcol;
      int          code;
      int          widx;
      int          wval;
      bit          pin;
      int          erow;
      int          ecol;
   } dir_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_op = OP_NONE;
   logic [ROW_W-1:0]      req_pixel_row = '0;
   logic [COL_W-1:0]      req_pixel_col = '0;
   logic [CODE_W-1:0]     req_depth_code = '0;
   logic [IDX_W-1:0]      req_write_index = '0;
   logic signed [Q_W-1:0] req_write_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [COL_W-1:0]      rsp_out_col;
   logic signed [Q_W-1:0] rsp_point_x;
   logic signed [Q_W-1:0] rsp_point_y;
   logic signed [Q_W-1:0] rsp_point_z;
   logic [ROW_W-1:0]      rsp_color_row;
   logic [COL_W-1:0]      rsp_color_col;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_AW-1:0]     csr_index = '0;
   logic [Q_W-1:0]        csr_wdata = '0;

   logic                  pin_en = 1'b0;
   logic [ROW_W-1:0]      pin_row = '0;
   logic [COL_W-1:0]      pin_col = '0;

   int  cfg_limit = 2047;
   int  cfg_dcx = 335020032;
   int  cfg_dcy = 251133952;
   int  cfg_difx = 1789;
   int  cfg_dify = 1795;
   int  cfg_ccx = 328176041;
   int  cfg_ccy = 277878963;
   int  depth_lut [TABLE_ENTRIES];
   int  coef_mem [COEF_N];
   bit  lut_loaded [TABLE_ENTRIES];
   int  loaded_codes [$];
   point_type pending_points [$];
   int  errors = 0;
   bit  idle_on = 1;
   int  stall_left = 0;

   depth_pixel_to_point_and_color_index DUT (.*);

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint sat_q(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      longint r;
      q = n / d;
      r = n % d;
      if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return sat_q((a * b + Q_HALF) >>> FRAC);
   endfunction

   function automatic longint rigid_row(input int base, input int trn,
                                        input longint x, input longint y,
                                        input longint z);
      return sat_q(qmul(coef_mem[base], x) + qmul(coef_mem[base+1], y)
                   + qmul(coef_mem[base+2], z) + longint'(coef_mem[trn]));
   endfunction

   function automatic longint color_index(input longint num, input longint tz,
                                          input longint center, input longint lim);
      longint v;
      longint p;
      v = floor_div(num * Q_ONE, tz) + center;
      p = (v + Q_HALF) >>> FRAC;
      if (p < 0) p = 0;
      if (p > lim - 1) p = lim - 1;
      return p;
   endfunction

   function automatic point_type project_pixel(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c,
                                               input logic [CODE_W-1:0] code);
      point_type p;
      longint x, y, z, tx, ty, tz;
      longint cr, cc;
      z = depth_lut[code];
      x = qmul(qmul(sat_q(longint'(c) * Q_ONE - cfg_dcx), z), cfg_difx);
      y = qmul(qmul(sat_q(longint'(r) * Q_ONE - cfg_dcy), z), cfg_dify);
      tx = rigid_row(C_ROT, C_TRN, x, y, z);
      ty = rigid_row(C_ROT + 3, C_TRN + 1, x, y, z);
      tz = rigid_row(C_ROT + 6, C_TRN + 2, x, y, z);
      p.row = r;
      p.col = c;
      p.x = x[Q_W-1:0];
      p.y = y[Q_W-1:0];
      p.z = z[Q_W-1:0];
      if (tz == 0) begin
         p.crow = '0;
         p.ccol = '0;
      end else begin
         cr = color_index(qmul(ty, coef_mem[C_FY]), tz, cfg_ccy, IMAGE_ROWS);
         cc = color_index(qmul(tx, coef_mem[C_FX]), tz, cfg_ccx, IMAGE_COLS);
         p.crow = cr[ROW_W-1:0];
         p.ccol = cc[COL_W-1:0];
      end
      return p;
   endfunction

   always @(posedge clock) begin
      point_type p;
      if (!reset && req_valid && !req_stall) begin
         case (req_op)
            OP_TABLE: depth_lut[req_write_index] = req_write_value;
            OP_COEF: if (req_write_index < COEF_N) coef_mem[req_write_index] = req_write_value;
            OP_PIXEL: if (req_depth_code < cfg_limit) begin
               p = project_pixel(req_pixel_row, req_pixel_col, req_depth_code);
               if (pin_en) begin
                  p.crow = pin_row;
                  p.ccol = pin_col;
               end
               pending_points.insert(pending_points.size(), p);
            end
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("unexpected response row %0d col %0d", rsp_out_row, rsp_out_col);
            errors++;
         end else begin
            e = pending_points.pop_front();
            if (rsp_out_row !== e.row) begin
               $error("out_row expected %0d actual %0d", e.row, rsp_out_row); errors++;
            end
            if (rsp_out_col !== e.col) begin
               $error("out_col expected %0d actual %0d", e.col, rsp_out_col); errors++;
            end
            if (rsp_point_x !== e.x) begin
               $error("point_x expected %h actual %h", e.x, rsp_point_x); errors++;
            end
            if (rsp_point_y !== e.y) begin
               $error("point_y expected %h actual %h", e.y, rsp_point_y); errors++;
            end
            if (rsp_point_z !== e.z) begin
               $error("point_z expected %h actual %h", e.z, rsp_point_z); errors++;
            end
            if (rsp_color_row !== e.crow) begin
               $error("color_row expected %0d actual %0d", e.crow, rsp_color_row); errors++;
            end
            if (rsp_color_col !== e.ccol) begin
               $error("color_col expected %0d actual %0d", e.ccol, rsp_color_col); errors++;
            end
         end
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= gap_len();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_req(input dprc_op_type op, input int r, input int c, input int code,
                           input int widx, input int wval, input bit pin = 0,
                           input int erow = 0, input int ecol = 0);
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel_row <= ROW_W'(r);
      req_pixel_col <= COL_W'(c);
      req_depth_code <= CODE_W'(code);
      req_write_index <= IDX_W'(widx);
      req_write_value <= wval;
      pin_en <= pin;
      pin_row <= ROW_W'(erow);
      pin_col <= COL_W'(ecol);
      if (op == OP_TABLE && !lut_loaded[widx]) begin
         lut_loaded[widx] = 1;
         loaded_codes.insert(loaded_codes.size(), widx);
      end
      do @(posedge clock); while (req_stall);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input int val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_AW'(idx);
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         0: cfg_limit = val & 32'h7ff;
         1: cfg_dcx = val;
         2: cfg_dcy = val;
         3: cfg_difx = val;
         4: cfg_dify = val;
         5: cfg_ccx = val;
         6: cfg_ccy = val;
         default: ;
      endcase
   endtask

   function automatic int rand_depth();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r < 3) return $urandom;
      return $urandom_range(419430, 10485760);
   endfunction

   function automatic int rand_coef(input int idx);
      if ($urandom_range(0, 9) == 0) return $urandom;
      if (idx <= C_FY) return 525 * 1048576 + $urandom_range(0, 20 * 1048576) - 10 * 1048576;
      if (idx >= C_TRN) return $urandom_range(0, 209715) - 104857;
      if (idx == 2 || idx == 6 || idx == 10) return 1048576 - $urandom_range(0, 20000);
      return $urandom_range(0, 100000) - 50000;
   endfunction

   task automatic random_req();
      int r;
      int code;
      int tries;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         tries = 0;
         do begin
            code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
            tries++;
         end while (code >= cfg_limit && tries < 20);
         if (code >= cfg_limit) code = $urandom_range(0, 9);
         send_req(OP_PIXEL, $urandom_range(0, 479), $urandom_range(0, 639), code,
                  $urandom, $urandom);
      end else if (r < 75) begin
         send_req(OP_PIXEL, $urandom_range(0, 479), $urandom_range(0, 639),
                  $urandom_range(cfg_limit, 2047), $urandom, $urandom);
      end else if (r < 85) begin
         send_req(OP_TABLE, $urandom, $urandom, $urandom, $urandom_range(0, 2047),
                  rand_depth());
      end else if (r < 95) begin
         code = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 2047) : $urandom_range(0, 15);
         send_req(OP_COEF, $urandom, $urandom, $urandom, code, rand_coef(code));
      end else begin
         send_req(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      dir_type dir_tab [$];
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 16; i++) send_req(OP_TABLE, 0, 0, 0, i, rand_depth());
      send_req(OP_TABLE, 0, 0, 0, 2047, rand_depth());
      for (int i = 0; i < 14; i++) send_req(OP_COEF, 0, 0, 0, i, rand_coef(i));

      dir_tab = '{
         '{OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0},
         '{OP_PIXEL, 479, 639, 15, 0, 0, 0, 0, 0},
         '{OP_PIXEL, 240, 320, 2047, 0, 0, 0, 0, 0},
         '{OP_NONE, 479, 639, 0, 2047, -1, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 2047, 32'h7fffffff, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 15, 32'h80000000, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 14, 32'h7fffffff, 0, 0, 0},
         '{OP_TABLE, 0, 0, 0, 3, 32'h7fffffff, 0, 0, 0},
         '{OP_PIXEL, 479, 0, 3, 0, 0, 0, 0, 0},
         '{OP_TABLE, 0, 0, 0, 4, 32'h80000000, 0, 0, 0},
         '{OP_PIXEL, 0, 639, 4, 0, 0, 0, 0, 0},
         '{OP_TABLE, 0, 0, 0, 5, 0, 0, 0, 0},
         '{OP_PIXEL, 100, 100, 5, 0, 0, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 8, 0, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 9, 0, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 10, 0, 0, 0, 0},
         '{OP_COEF, 0, 0, 0, 13, 0, 0, 0, 0},
         '{OP_PIXEL, 10, 20, 1, 0, 0, 1, 0, 0},
         '{OP_PIXEL, 479, 639, 2, 0, 0, 1, 0, 0},
         '{OP_PIXEL, 0, 0, 5, 0, 0, 1, 0, 0},
         '{OP_COEF, 0, 0, 0, 13, 1048576, 0, 0, 0},
         '{OP_PIXEL, 0, 0, 6, 0, 0, 0, 0, 0},
         '{OP_TABLE, 0, 0, 0, 1030, 2097152, 0, 0, 0}
      };
      foreach (dir_tab[i])
         send_req(dir_tab[i].op, dir_tab[i].prow, dir_tab[i].pcol, dir_tab[i].code,
                  dir_tab[i].widx, dir_tab[i].wval, dir_tab[i].pin,
                  dir_tab[i].erow, dir_tab[i].ecol);

      for (phase = 0; phase < 8; phase++) begin
         drain();
         idle_on = (phase % 3 != 1);
         case (phase)
            0: ;
            1: begin
               csr_write(0, 10);
               csr_write(1, 32'h80000000);
               csr_write(2, 32'h80000000);
               csr_write(3, 32'h7fffffff);
               csr_write(4, 32'h7fffffff);
               csr_write(5, 32'h80000000);
               csr_write(6, 32'h80000000);
               csr_write(7, $urandom);
            end
            2: begin
               csr_write(0, 2047);
               csr_write(1, 32'h7fffffff);
               csr_write(2, 32'h7fffffff);
               csr_write(3, 32'h80000000);
               csr_write(4, 32'h80000000);
               csr_write(5, 32'h7fffffff);
               csr_write(6, 32'h7fffffff);
            end
            default: begin
               csr_write(0, $urandom_range(10, 2047));
               csr_write(1, 320 * 1048576 + $urandom_range(0, 41943040) - 20971520);
               csr_write(2, 240 * 1048576 + $urandom_range(0, 41943040) - 20971520);
               csr_write(3, $urandom_range(1600, 2000));
               csr_write(4, $urandom_range(1600, 2000));
               csr_write(5, 320 * 1048576 + $urandom_range(0, 41943040) - 20971520);
               csr_write(6, 240 * 1048576 + $urandom_range(0, 41943040) - 20971520);
            end
         endcase
         csr_wr_en <= 1'b0;
         for (int n = 0; n < 125; n++) begin
            random_req();
            if (phase == 4 && n == 60) begin
               req_valid <= 1'b0;
               while (pending_points.size() != 0) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
src/dprc_pkg.sv
src/dprc_front.sv
src/dprc_queue.sv
src/dprc_div.sv
src/dprc_back.sv
src/depth_pixel_to_point_and_color_index.sv
tb/depth_pixel_to_point_and_color_index_tb.sv
